FILE: rtl/clup_pkg.sv
// ----------------------------------------------------------------------------
// clup_pkg
// Shared types and constants of the 2:3 cubic Lagrange upsampler: job
// descriptors passed from the front end to the back end, configuration
// register indexes and reciprocal constants for the constant divisions.
// ----------------------------------------------------------------------------
package clup_pkg;

    // job kinds, one per input word that produces results
    localparam logic [1:0] KIND_PASS = 2'd0;  // passthrough, one result
    localparam logic [1:0] KIND_LIN3 = 2'd1;  // final pair, linear thirds
    localparam logic [1:0] KIND_CUB3 = 2'd2;  // one pair with cubic taps
    localparam logic [1:0] KIND_CUB6 = 2'd3;  // cubic pair, then final pair

    // configuration register indexes
    localparam logic CFG_IDX_RESAMPLE = 1'b0;
    localparam logic CFG_IDX_VOLUME   = 1'b1;

    localparam logic [6:0] VOLUME_MAX   = 7'd100;
    localparam logic [6:0] VOLUME_RESET = 7'd100;

    // floor(x / d) = (x * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT over our ranges
    localparam int          RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_100   = 24'd10737419;

    // gain multiplier = 2 * volume * RECIP_100
    localparam logic [31:0] GAIN_K_RESET =
        32'(64'(VOLUME_RESET) * 64'd2 * 64'(RECIP_100));

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // samples of one channel needed to compute all results of a job
    typedef struct packed {
        logic signed [15:0] h;
        logic signed [15:0] s0;
        logic signed [15:0] s1;
        logic signed [15:0] s2;
        logic signed [15:0] s3;
    } t_chan;

    // channel 0 is left, channel 1 is right
    typedef struct packed {
        logic [1:0]       kind;
        t_chan [1:0]      ch;
    } t_job;

endpackage

FILE: rtl/clup_front.sv
// ----------------------------------------------------------------------------
// clup_front
// Input side: accepts sample words, keeps the chunk window and history, and
// turns each word that produces results into one job for the back end.
// ----------------------------------------------------------------------------
module clup_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_resample_en,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [31:0]         i_s_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic                i_s_tlast,   // chunk_end
    input  logic                i_full,
    output logic                o_push,
    output clup_pkg::t_job      o_job
);

    logic               w_acc;
    logic signed [15:0] w_in [2];

    logic signed [15:0] r_win [2][3];
    logic signed [15:0] n_win [2][3];
    logic signed [15:0] r_hist [2];
    logic signed [15:0] n_hist [2];
    logic [1:0]         r_pending;
    logic [1:0]         n_pending;

    assign o_s_tready = !i_full;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_in[0]    = i_s_tdata[15:0];
    assign w_in[1]    = i_s_tdata[31:16];

    // classify the word and build the job
    always_comb begin
        n_win     = r_win;
        n_hist    = r_hist;
        n_pending = r_pending;
        o_push    = 1'b0;
        o_job.kind = clup_pkg::KIND_PASS;
        for (int c = 0; c < 2; c++) begin
            o_job.ch[c].h  = r_hist[c];
            o_job.ch[c].s0 = w_in[c];
            o_job.ch[c].s1 = w_in[c];
            o_job.ch[c].s2 = w_in[c];
            o_job.ch[c].s3 = w_in[c];
        end
        if (w_acc) begin
            if (!i_resample_en) begin
                // passthrough, window state untouched
                o_push = 1'b1;
            end else begin
                case (r_pending)
                    2'd3: begin
                        o_push     = 1'b1;
                        o_job.kind = i_s_tlast ? clup_pkg::KIND_CUB6
                                               : clup_pkg::KIND_CUB3;
                        for (int c = 0; c < 2; c++) begin
                            o_job.ch[c].s0 = r_win[c][0];
                            o_job.ch[c].s1 = r_win[c][1];
                            o_job.ch[c].s2 = r_win[c][2];
                            if (i_s_tlast) begin
                                n_hist[c] = w_in[c];
                            end else begin
                                n_hist[c]   = r_win[c][1];
                                n_win[c][0] = r_win[c][2];
                                n_win[c][1] = w_in[c];
                            end
                        end
                        n_pending = i_s_tlast ? 2'd0 : 2'd2;
                    end
                    2'd2: begin
                        if (i_s_tlast) begin
                            o_push     = 1'b1;
                            o_job.kind = clup_pkg::KIND_LIN3;
                            for (int c = 0; c < 2; c++) begin
                                o_job.ch[c].s0 = r_win[c][0];
                                o_job.ch[c].s1 = r_win[c][1];
                                n_hist[c]      = r_win[c][1];
                            end
                            n_pending = 2'd0;
                        end else begin
                            for (int c = 0; c < 2; c++) begin
                                n_win[c][2] = w_in[c];
                            end
                            n_pending = 2'd3;
                        end
                    end
                    2'd1: begin
                        if (i_s_tlast) begin
                            // pair with its second sample standing in as lookahead
                            o_push     = 1'b1;
                            o_job.kind = clup_pkg::KIND_LIN3;
                            for (int c = 0; c < 2; c++) begin
                                o_job.ch[c].s0 = r_win[c][0];
                                n_hist[c]      = w_in[c];
                            end
                            n_pending = 2'd0;
                        end else begin
                            for (int c = 0; c < 2; c++) begin
                                n_win[c][1] = w_in[c];
                            end
                            n_pending = 2'd2;
                        end
                    end
                    default: begin
                        // single-sample chunk is dropped
                        if (i_s_tlast) begin
                            n_pending = 2'd0;
                        end else begin
                            for (int c = 0; c < 2; c++) begin
                                n_win[c][0] = w_in[c];
                            end
                            n_pending = 2'd1;
                        end
                    end
                endcase
            end
        end
    end

    // window and history state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_hist[0] <= '0;
            r_hist[1] <= '0;
        end else begin
            r_pending <= n_pending;
            r_hist    <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("job pushed into a full queue");

    a_chunk_end_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_resample_en && i_s_tlast) |=> (r_pending == 2'd0))
        else $error("window not emptied at chunk end");

    a_pass_keeps_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_resample_en) |=> $stable(r_pending))
        else $error("passthrough word changed the window");

endmodule

FILE: rtl/clup_queue.sv
// ----------------------------------------------------------------------------
// clup_queue
// Short job queue between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module clup_queue #(
    parameter int DEPTH = clup_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clup_pkg::t_job      i_job,
    output logic                o_full,
    output logic                o_valid,
    output clup_pkg::t_job      o_job,
    input  logic                i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clup_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/clup_back.sv
// ----------------------------------------------------------------------------
// clup_back
// Output side: expands each job into results, one per unstalled cycle, and runs
// them through the tap sum, rounding divide, saturation and gain pipeline.
// ----------------------------------------------------------------------------
module clup_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  clup_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  logic [31:0]         i_gain_k,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [31:0]         o_m_tdata,   // [15:0] left_out, [31:16] right_out
    output logic                o_m_tlast    // last_of_run
);

    localparam logic [1:0] MODE_COPY   = 2'd0;
    localparam logic [1:0] MODE_CUBIC  = 2'd1;
    localparam logic [1:0] MODE_LINEAR = 2'd2;

    localparam logic [2:0] SRC_H  = 3'd0;
    localparam logic [2:0] SRC_S0 = 3'd1;
    localparam logic [2:0] SRC_S1 = 3'd2;
    localparam logic [2:0] SRC_S2 = 3'd3;
    localparam logic [2:0] SRC_S3 = 3'd4;

    localparam logic [30:0] RECIP_81  = 31'd13256072;
    localparam logic [30:0] RECIP_3   = 31'd357913942;
    localparam logic [30:0] RECIP_ONE = 31'(64'd1 << clup_pkg::RECIP_SHIFT);
    localparam logic [21:0] ROUND_81  = 22'd40;

    function automatic logic [2:0] f_last_idx(input logic [1:0] kind);
        logic [2:0] idx;
        case (kind)
            clup_pkg::KIND_PASS: idx = 3'd0;
            clup_pkg::KIND_LIN3: idx = 3'd2;
            clup_pkg::KIND_CUB3: idx = 3'd2;
            clup_pkg::KIND_CUB6: idx = 3'd5;
            default:             idx = 3'd0;
        endcase
        return idx;
    endfunction

    logic               w_adv;
    logic               w_issue;
    logic               w_is_last;
    logic [2:0]         r_idx;
    logic [2:0]         n_idx;
    logic [1:0]         n_mode;
    logic [2:0]         w_sel [4];
    logic signed [15:0] w_src [2][5];
    logic signed [15:0] n_s1_x [2][4];

    logic               r_s1_valid;
    logic               r_s1_last;
    logic [1:0]         r_s1_mode;
    logic signed [15:0] r_s1_x [2][4];

    logic               r_s2_valid;
    logic               r_s2_last;
    logic [1:0]         r_s2_mode;
    logic signed [22:0] r_s2_sum [2];
    logic signed [22:0] n_s2_sum [2];

    logic               r_s3_valid;
    logic               r_s3_last;
    logic               r_s3_neg [2];
    logic [16:0]        r_s3_q [2];
    logic signed [22:0] w_abs [2];
    logic [21:0]        w_mag [2];
    logic [30:0]        w_k;
    logic [52:0]        w_prod [2];

    logic               r_s4_valid;
    logic               r_s4_last;
    logic               r_s4_neg [2];
    logic [15:0]        r_s4_mag [2];
    logic [15:0]        n_s4_mag [2];

    logic               r_s5_valid;
    logic               r_s5_last;
    logic               r_s5_neg [2];
    logic [16:0]        r_s5_q [2];
    logic [47:0]        w_gprod [2];

    logic               r_out_valid;
    logic               r_out_last;
    logic [15:0]        r_out_data [2];
    logic [15:0]        n_out_data [2];

    // whole pipeline moves when the output register is free or being taken
    assign w_adv     = !r_out_valid || i_m_tready;
    assign w_issue   = w_adv && i_job_valid;
    assign w_is_last = (r_idx == f_last_idx(i_job.kind));
    assign o_job_pop = w_issue && w_is_last;

    always_comb begin
        n_idx = r_idx;
        if (w_issue) begin
            n_idx = w_is_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    // pick the operation and its operands for the current result
    always_comb begin
        n_mode   = MODE_COPY;
        w_sel[0] = SRC_S0;
        w_sel[1] = SRC_S0;
        w_sel[2] = SRC_S0;
        w_sel[3] = SRC_S0;
        case (r_idx)
            3'd1: begin
                if (i_job.kind == clup_pkg::KIND_LIN3) begin
                    n_mode   = MODE_LINEAR;
                    w_sel[0] = SRC_S0;
                    w_sel[1] = SRC_S1;
                end else begin
                    n_mode   = MODE_CUBIC;
                    w_sel[0] = SRC_H;
                    w_sel[1] = SRC_S0;
                    w_sel[2] = SRC_S1;
                    w_sel[3] = SRC_S2;
                end
            end
            3'd2: begin
                if (i_job.kind == clup_pkg::KIND_LIN3) begin
                    n_mode   = MODE_LINEAR;
                    w_sel[0] = SRC_S2;
                    w_sel[1] = SRC_S1;
                end else begin
                    // mirrored taps: s3 weighted -4, s2 30, s1 60, s0 -5
                    n_mode   = MODE_CUBIC;
                    w_sel[0] = SRC_S3;
                    w_sel[1] = SRC_S2;
                    w_sel[2] = SRC_S1;
                    w_sel[3] = SRC_S0;
                end
            end
            3'd3: begin
                w_sel[0] = SRC_S2;
            end
            3'd4: begin
                n_mode   = MODE_LINEAR;
                w_sel[0] = SRC_S2;
                w_sel[1] = SRC_S3;
            end
            3'd5: begin
                n_mode   = MODE_LINEAR;
                w_sel[0] = SRC_S3;
                w_sel[1] = SRC_S3;
            end
            default: begin
                w_sel[0] = SRC_S0;
            end
        endcase
        for (int c = 0; c < 2; c++) begin
            w_src[c][0] = i_job.ch[c].h;
            w_src[c][1] = i_job.ch[c].s0;
            w_src[c][2] = i_job.ch[c].s1;
            w_src[c][3] = i_job.ch[c].s2;
            w_src[c][4] = i_job.ch[c].s3;
            for (int k = 0; k < 4; k++) begin
                n_s1_x[c][k] = w_src[c][w_sel[k]];
            end
        end
    end

    // weighted tap sum
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            case (r_s1_mode)
                MODE_CUBIC: n_s2_sum[c] =
                      23'sd30 * 23'($signed(r_s1_x[c][1]))
                    + 23'sd60 * 23'($signed(r_s1_x[c][2]))
                    - 23'sd4  * 23'($signed(r_s1_x[c][0]))
                    - 23'sd5  * 23'($signed(r_s1_x[c][3]));
                MODE_LINEAR: n_s2_sum[c] =
                      23'($signed(r_s1_x[c][0]))
                    + 23'sd2 * 23'($signed(r_s1_x[c][1]));
                default: n_s2_sum[c] = 23'($signed(r_s1_x[c][0]));
            endcase
        end
    end

    // magnitude divide by reciprocal multiply, rounding half away for cubic taps
    always_comb begin
        case (r_s2_mode)
            MODE_CUBIC:  w_k = RECIP_81;
            MODE_LINEAR: w_k = RECIP_3;
            default:     w_k = RECIP_ONE;
        endcase
        for (int c = 0; c < 2; c++) begin
            w_abs[c]  = r_s2_sum[c][22] ? -r_s2_sum[c] : r_s2_sum[c];
            w_mag[c]  = w_abs[c][21:0] + ((r_s2_mode == MODE_CUBIC) ? ROUND_81 : 22'd0);
            w_prod[c] = 53'(w_mag[c]) * 53'(w_k);
        end
    end

    // saturate the interpolated sample to int16 range
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            if (r_s3_neg[c]) begin
                n_s4_mag[c] = (r_s3_q[c] > 17'd32768) ? 16'd32768 : r_s3_q[c][15:0];
            end else begin
                n_s4_mag[c] = (r_s3_q[c] > 17'd32767) ? 16'd32767 : r_s3_q[c][15:0];
            end
        end
    end

    // volume gain, divide by 100 folded into the gain multiplier
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_gprod[c] = 48'(r_s4_mag[c]) * 48'(i_gain_k);
        end
    end

    // sign and final int16 saturation
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            if (r_s5_neg[c]) begin
                n_out_data[c] = (r_s5_q[c] >= 17'd32768) ? 16'h8000 : -r_s5_q[c][15:0];
            end else begin
                n_out_data[c] = (r_s5_q[c] >= 17'd32768) ? 16'h7FFF : r_s5_q[c][15:0];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (w_adv) begin
                r_s1_valid  <= w_issue;
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_s4_valid  <= r_s3_valid;
                r_s5_valid  <= r_s4_valid;
                r_out_valid <= r_s5_valid;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_mode  <= n_mode;
            r_s1_last  <= w_is_last;
            r_s1_x     <= n_s1_x;
            r_s2_mode  <= r_s1_mode;
            r_s2_last  <= r_s1_last;
            r_s2_sum   <= n_s2_sum;
            r_s3_last  <= r_s2_last;
            r_s4_last  <= r_s3_last;
            r_s4_neg   <= r_s3_neg;
            r_s4_mag   <= n_s4_mag;
            r_s5_last  <= r_s4_last;
            r_s5_neg   <= r_s4_neg;
            r_out_last <= r_s5_last;
            r_out_data <= n_out_data;
            for (int c = 0; c < 2; c++) begin
                r_s3_neg[c] <= r_s2_sum[c][22];
                r_s3_q[c]   <= w_prod[c][clup_pkg::RECIP_SHIFT +: 17];
                r_s5_q[c]   <= w_gprod[c][clup_pkg::RECIP_SHIFT +: 17];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {r_out_data[1], r_out_data[0]};

    a_mid_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> i_job_valid)
        else $error("job left the queue before all its results issued");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (r_idx <= f_last_idx(i_job.kind)))
        else $error("result index beyond the job's result count");

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_s1_valid && r_s1_last))
        else $error("job retired without a last result");

endmodule

FILE: rtl/cubic_lagrange_upsampler_2to3_unit.sv
// ----------------------------------------------------------------------------
// cubic_lagrange_upsampler_2to3_unit
// Stereo 2:3 cubic Lagrange upsampler with volume gain.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream i_s_*: one stereo sample word per transfer, tlast marks the
//   final word of a chunk. Master stream o_m_*: result words, tlast set on
//   the final result caused by an input word.
//   With resampling on, each aligned pair gives three results (passthrough
//   sample and two cubic taps); a chunk's final pair uses linear thirds, an
//   odd final sample is dropped. With resampling off, each word gives one.
//   Config port: write resample_enable (index 0) or game_volume (index 1)
//   while the block is idle; volume above 100 is clamped to 100.
//   Throughput: the back end issues one result per clock while the receiver
//   is not stalling; a pair gives three results (six for the word that closes
//   a chunk after a cubic pair) and a passthrough word one. The front end
//   takes a word per clock while the job queue has room.
//   Path: each job passes the queue, then the operand select, tap sum,
//   divide, saturate, gain and output registers.
//   Reset empties window, history and queue; resample on, volume 100.
//   A stalled receiver freezes the back-end pipeline; the queue keeps
//   taking words until it is full, then o_s_tready drops.
// ----------------------------------------------------------------------------
module cubic_lagrange_upsampler_2to3_unit #(
    parameter int QUEUE_DEPTH = clup_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [15:0] left_sample, [31:16] right_sample
    input  logic        i_s_tlast,    // chunk_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [15:0] left_out, [31:16] right_out
    output logic        o_m_tlast,    // last_of_run
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_wdata
);

    logic               r_resample_en;
    logic               n_resample_en;
    logic [31:0]        r_gain_k;
    logic [31:0]        n_gain_k;
    logic [6:0]         w_volume;

    logic               w_push;
    logic               w_full;
    logic               w_job_valid;
    logic               w_pop;
    clup_pkg::t_job     w_front_job;
    clup_pkg::t_job     w_head_job;

    // configuration writes, gain stored as a ready-made reciprocal multiplier
    always_comb begin
        n_resample_en = r_resample_en;
        n_gain_k      = r_gain_k;
        w_volume      = (i_cfg_wdata > clup_pkg::VOLUME_MAX) ? clup_pkg::VOLUME_MAX
                                                             : i_cfg_wdata;
        if (i_cfg_we) begin
            case (i_cfg_index)
                clup_pkg::CFG_IDX_RESAMPLE: n_resample_en = i_cfg_wdata[0];
                clup_pkg::CFG_IDX_VOLUME:
                    n_gain_k = 32'({w_volume, 1'b0}) * 32'(clup_pkg::RECIP_100);
                default: n_resample_en = r_resample_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resample_en <= 1'b1;
            r_gain_k      <= clup_pkg::GAIN_K_RESET;
        end else begin
            r_resample_en <= n_resample_en;
            r_gain_k      <= n_gain_k;
        end
    end

    clup_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_resample_en (r_resample_en),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_job         (w_front_job)
    );

    clup_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_job   (w_head_job),
        .i_pop   (w_pop)
    );

    clup_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_head_job),
        .o_job_pop   (w_pop),
        .i_gain_k    (r_gain_k),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

FILE: tb/cubic_lagrange_upsampler_2to3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_lagrange_upsampler_2to3_checker
// Watches the sample stream, the result stream and the register port of the
// 2:3 upsampler. Keeps its own window, history and register copies, works out
// the upsampled and gain-scaled words for every accepted input word, and
// compares each accepted result word with the oldest one still waiting.
// ----------------------------------------------------------------------------
module cubic_lagrange_upsampler_2to3_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // [15:0] left_sample, [31:16] right_sample
    input  logic        i_s_tlast,    // chunk_end
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // [15:0] left_out, [31:16] right_out
    input  logic        i_m_tlast,    // last_of_run
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_wdata,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        last;
    } t_out_word;

    t_out_word upsampled_words[$];

    // register copies
    logic       resample_on;
    logic [6:0] volume;

    // interpolation state per channel, 0 left and 1 right
    int win_s[2][3];
    int hist_s[2];
    int pend_cnt;
    int seq_s[2][4];
    int tap_s[2][6];

    function automatic int clip16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // divide by 81, rounding half away from zero
    function automatic int round_div81(input int y);
        return clip16(((y >= 0) ? y + 40 : y - 40) / 81);
    endfunction

    function automatic logic [15:0] scale_volume(input int y);
        int g;
        g = int'(volume) * 200 / 100;
        return 16'(clip16(y * g / 100));
    endfunction

    // one channel: cubic pair once lookahead is there, linear thirds at chunk end
    task automatic interp_channel(input int ch, input int n, input bit at_end,
                                  output int cnt);
        int k;
        int i;
        int j;
        int s0;
        int s1;
        int s2;
        k = 0;
        i = 0;
        if (n == 4) begin
            tap_s[ch][0] = seq_s[ch][0];
            tap_s[ch][1] = round_div81(-4 * hist_s[ch] + 30 * seq_s[ch][0]
                                       + 60 * seq_s[ch][1] - 5 * seq_s[ch][2]);
            tap_s[ch][2] = round_div81(-5 * seq_s[ch][0] + 60 * seq_s[ch][1]
                                       + 30 * seq_s[ch][2] - 4 * seq_s[ch][3]);
            hist_s[ch] = seq_s[ch][1];
            k = 3;
            i = 2;
        end
        if (!at_end) begin
            for (j = 0; (i + j < n) && (j < 3); j++) win_s[ch][j] = seq_s[ch][i + j];
        end else if (n >= 2) begin
            while (i + 1 < n) begin
                s0 = seq_s[ch][i];
                s1 = seq_s[ch][i + 1];
                s2 = (i + 2 < n) ? seq_s[ch][i + 2] : s1;
                tap_s[ch][k]     = s0;
                tap_s[ch][k + 1] = (s0 + 2 * s1) / 3;
                tap_s[ch][k + 2] = (2 * s1 + s2) / 3;
                hist_s[ch] = s1;
                k = k + 3;
                i = i + 2;
            end
        end
        cnt = k;
    endtask

    task automatic predict_word(input logic signed [15:0] l, input logic signed [15:0] r,
                                input logic at_end);
        int lv;
        int rv;
        int n;
        int cnt;
        int ch;
        int j;
        t_out_word w;
        lv = l;
        rv = r;
        if (!resample_on) begin
            w.left  = scale_volume(lv);
            w.right = scale_volume(rv);
            w.last  = 1'b1;
            upsampled_words.push_back(w);
        end else begin
            n = pend_cnt;
            for (ch = 0; ch < 2; ch++) begin
                for (j = 0; j < n; j++) seq_s[ch][j] = win_s[ch][j];
            end
            seq_s[0][n] = lv;
            seq_s[1][n] = rv;
            n = n + 1;
            interp_channel(0, n, at_end, cnt);
            interp_channel(1, n, at_end, cnt);
            pend_cnt = at_end ? 0 : ((n == 4) ? 2 : n);
            for (j = 0; j < cnt; j++) begin
                w.left  = scale_volume(tap_s[0][j]);
                w.right = scale_volume(tap_s[1][j]);
                w.last  = (j == cnt - 1);
                upsampled_words.push_back(w);
            end
        end
    endtask

    task automatic flag_mismatch(input t_out_word exp_w, input bit have_exp);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= REPORT_LIMIT) begin
            if (have_exp)
                $display("%0t mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                         $realtime, $signed(exp_w.left), $signed(exp_w.right), exp_w.last,
                         $signed(i_m_tdata[15:0]), $signed(i_m_tdata[31:16]), i_m_tlast);
            else
                $display("%0t unexpected word: got L=%0d R=%0d last=%0b", $realtime,
                         $signed(i_m_tdata[15:0]), $signed(i_m_tdata[31:16]), i_m_tlast);
        end
    endtask

    // track registers, predict on accepted inputs, compare accepted results
    always @(posedge i_clk) begin
        t_out_word exp_w;
        int ch;
        int j;
        if (!i_rst_n) begin
            resample_on  = 1'b1;
            volume       = clup_pkg::VOLUME_RESET;
            o_fail_count = 0;
            for (ch = 0; ch < 2; ch++) begin
                for (j = 0; j < 3; j++) win_s[ch][j] = 0;
                hist_s[ch] = 0;
            end
            pend_cnt = 0;
            upsampled_words.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == clup_pkg::CFG_IDX_RESAMPLE)
                    resample_on = i_cfg_wdata[0];
                else
                    volume = (i_cfg_wdata > clup_pkg::VOLUME_MAX) ? clup_pkg::VOLUME_MAX
                                                                  : i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (upsampled_words.size() == 0) begin
                    exp_w = '0;
                    flag_mismatch(exp_w, 1'b0);
                end else begin
                    exp_w = upsampled_words.pop_front();
                    if (exp_w.left !== i_m_tdata[15:0] || exp_w.right !== i_m_tdata[31:16]
                        || exp_w.last !== i_m_tlast)
                        flag_mismatch(exp_w, 1'b1);
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_word(i_s_tdata[15:0], i_s_tdata[31:16], i_s_tlast);
        end
        o_pending = upsampled_words.size();
    end

endmodule

FILE: tb/cubic_lagrange_upsampler_2to3_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_lagrange_upsampler_2to3_unit_tb
// Drives stereo sample chunks into the 2:3 upsampler: a short directed set of
// extreme values and chunk shapes, then random chunks under several register
// settings and source/sink idling patterns. The checker predicts and compares;
// this module makes stimulus, runs a stall watchdog and reports the verdict.
// ----------------------------------------------------------------------------
module cubic_lagrange_upsampler_2to3_unit_tb;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = '0;    // [15:0] left_sample, [31:16] right_sample
    logic        i_s_tlast   = 1'b0;  // chunk_end
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;           // [15:0] left_out, [31:16] right_out
    logic        o_m_tlast;           // last_of_run
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int pending_words;
    int fail_count;

    cubic_lagrange_upsampler_2to3_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    cubic_lagrange_upsampler_2to3_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending_words),
        .o_fail_count (fail_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result sink with random back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    // one word on the sample stream, with optional source gaps
    task automatic send_word(input logic [15:0] l, input logic [15:0] r, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {r, l};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // chunk of len words; a noisy chunk scatters tlast at random
    task automatic send_chunk(input int len, input bit noisy);
        int i;
        logic last;
        for (i = 0; i < len; i++) begin
            last = (i == len - 1);
            if (noisy && $urandom_range(4) == 0) last = 1'($urandom_range(1));
            send_word(rand_sample(), rand_sample(), last);
        end
    endtask

    // sender holds off until every predicted word is out and the block settles
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int src, input int sink, input bit rs_on,
                             input logic [6:0] vol, input int items);
        int sent;
        int len;
        wait_drained();
        write_reg(clup_pkg::CFG_IDX_RESAMPLE, {6'd0, rs_on});
        write_reg(clup_pkg::CFG_IDX_VOLUME, vol);
        src_idle_pct   = src;
        sink_stall_pct = sink;
        sent = 0;
        while (sent < items) begin
            if (!rs_on) begin
                send_word(rand_sample(), rand_sample(), 1'($urandom_range(1)));
                sent = sent + 1;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(16, 1) : $urandom_range(6, 1);
                send_chunk(len, $urandom_range(9) < 2);
                sent = sent + len;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: resampling at unity gain
        write_reg(clup_pkg::CFG_IDX_RESAMPLE, 7'd1);
        write_reg(clup_pkg::CFG_IDX_VOLUME, 7'd50);
        // full-scale swing, cubic overshoot saturates, closes after a cubic pair
        send_word(16'h8000, 16'h7fff, 1'b0);
        send_word(16'h7fff, 16'h8000, 1'b0);
        send_word(16'h7fff, 16'h8000, 1'b0);
        send_word(16'h8000, 16'h7fff, 1'b1);
        // single-sample chunk is dropped
        send_word(16'd1234, 16'hfb2e, 1'b1);
        // two-sample chunk, linear thirds with missing lookahead
        send_word(16'd100, 16'hfff9, 1'b0);
        send_word(16'hfff9, 16'd100, 1'b1);
        // three-sample chunk, odd last sample dropped
        send_word(16'd5, 16'hfffb, 1'b0);
        send_word(16'hfffb, 16'd5, 1'b0);
        send_word(16'h7fff, 16'h8000, 1'b1);
        // six-sample chunk, cubic pair on lookahead then the rest at the end
        send_word(16'h8ad0, 16'd3000, 1'b0);
        send_word(16'd12345, 16'hffff, 1'b0);
        send_word(16'hffff, 16'h7fff, 1'b0);
        send_word(16'd0, 16'h8000, 1'b0);
        send_word(16'h7fff, 16'd77, 1'b0);
        send_word(16'h8000, 16'hd000, 1'b1);

        // directed: passthrough, volume above range clamps to full gain
        wait_drained();
        write_reg(clup_pkg::CFG_IDX_RESAMPLE, 7'd0);
        write_reg(clup_pkg::CFG_IDX_VOLUME, 7'd127);
        send_word(16'h7fff, 16'h8000, 1'b1);
        send_word(16'h8000, 16'hffff, 1'b0);
        send_word(16'hffff, 16'd16384, 1'b1);
        send_word(16'd16384, 16'h7fff, 1'b0);
        wait_drained();
        write_reg(clup_pkg::CFG_IDX_VOLUME, 7'd0);
        send_word(16'h7fff, 16'h8000, 1'b0);
        send_word(16'hffff, 16'd1, 1'b1);

        // random chunks over idling patterns and settings
        run_phase(0, 0, 1'b1, 7'd50, 40);
        run_phase(66, 0, 1'b1, 7'($urandom_range(127)), 40);
        run_phase(0, 66, 1'b1, 7'd100, 40);
        run_phase(32, 32, 1'b0, 7'd37, 30);
        run_phase(32, 32, 1'b1, 7'd0, 30);
        run_phase(0, 0, 1'b1, 7'($urandom_range(127)), 20);

        wait_drained();
        if (fail_count == 0 && pending_words == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: cubic_lagrange_upsampler_2to3_unit.f
rtl/clup_pkg.sv
rtl/clup_front.sv
rtl/clup_queue.sv
rtl/clup_back.sv
rtl/cubic_lagrange_upsampler_2to3_unit.sv
tb/cubic_lagrange_upsampler_2to3_checker.sv
tb/cubic_lagrange_upsampler_2to3_unit_tb.sv
